// ===== hdl/power_iteration_eigen_unit_macros.svh =====
// ----------------------------------------------------------------------------
// power_iteration_eigen_unit_macros.svh
// Assertion macros shared by the power iteration unit.
// ----------------------------------------------------------------------------
`ifndef POWER_ITERATION_EIGEN_UNIT_MACROS_SVH
`define POWER_ITERATION_EIGEN_UNIT_MACROS_SVH

// Assert that a property holds at every rising edge of clk, off during reset.
`define PIE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Assert a non-overlapping implication.
`define PIE_IMPLIES(label, lhs, rhs, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (lhs) |=> (rhs)) \
		else $error(msg);

`endif

// ===== hdl/pie_pkg.sv =====
// ----------------------------------------------------------------------------
// pie_pkg
// Types and constants for the power iteration eigenvalue unit.
// ----------------------------------------------------------------------------
package pie_pkg;

	localparam int MAX_SIZE   = 8;
	localparam int VALUE_BITS = 32;
	localparam int FRAC_BITS  = 16;
	localparam int IDX_BITS   = 3;
	localparam int MEM_DEPTH  = MAX_SIZE * MAX_SIZE;
	localparam int MADDR_BITS = 6;

	localparam logic [1:0] CMD_LOAD_MATRIX = 2'd0;
	localparam logic [1:0] CMD_LOAD_VECTOR = 2'd1;
	localparam logic [1:0] CMD_RUN         = 2'd2;

	localparam logic [1:0] REG_MATRIX_SIZE   = 2'd0;
	localparam logic [1:0] REG_TOLERANCE     = 2'd1;
	localparam logic [1:0] REG_ITERATION_CAP = 2'd2;

	localparam logic KIND_VALUE  = 1'b0;
	localparam logic KIND_VECTOR = 1'b1;

	localparam logic signed [31:0] VMAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] VMIN = 32'sh8000_0000;

	typedef struct packed {
		logic [1:0]         command;
		logic [2:0]         row;
		logic [2:0]         col;
		logic signed [31:0] value;
	} in_item_t;

	typedef struct packed {
		logic               kind;
		logic [2:0]         index;
		logic signed [31:0] result_value;
		logic               converged;
		logic               last;
	} out_item_t;

	// Saturating signed add.
	function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [32:0] s;
		s = 33'(a) + 33'(b);
		if (s > 33'(VMAX))      sat_add = VMAX;
		else if (s < 33'(VMIN)) sat_add = VMIN;
		else                    sat_add = s[31:0];
	endfunction

	// Q16.16 product rounded by floor and saturated.
	function automatic logic signed [31:0] qsat(input logic signed [63:0] p);
		logic signed [47:0] q;
		q = p[63:16];
		if (q > 48'(VMAX))      qsat = VMAX;
		else if (q < 48'(VMIN)) qsat = VMIN;
		else                    qsat = q[31:0];
	endfunction

endpackage

// ===== hdl/pie_ram.sv =====
// ----------------------------------------------------------------------------
// pie_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module pie_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== hdl/power_iteration_eigen_unit.sv =====
// ----------------------------------------------------------------------------
// power_iteration_eigen_unit
// Power iteration for the dominant eigenvalue of a matrix in Q16.16.
// ----------------------------------------------------------------------------
// channel   dir  handshake          payload
// in        in   in_valid/in_ready  pie_pkg::in_item_t
// out       out  out_valid/out_ready pie_pkg::out_item_t
// cfg       in   cfg_we             cfg_index, cfg_data
//
// Loads are accepted back to back while the unit is idle.
// A run copies the start vector into the work vector; each iteration then
// sums the squares, takes the square root, divides each element by it,
// forms the matrix-vector product one entry at a time and then the estimate.
// After the last iteration a final normalize and the emit of the estimate and
// the vector follow. Results leave through one output register; a stall on
// out holds the sequencer. The stores need no clearing after reset.
// ----------------------------------------------------------------------------
`include "power_iteration_eigen_unit_macros.svh"

module power_iteration_eigen_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  pie_pkg::in_item_t   in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output pie_pkg::out_item_t  out_item,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [30:0]         cfg_data
);
	// sequencer states
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_COPY  = 4'd1;  // vector_store -> work vector
	localparam logic [3:0] ST_SQR   = 4'd2;  // sum of squares, one element a cycle
	localparam logic [3:0] ST_SQRT  = 4'd3;  // bit-serial square root
	localparam logic [3:0] ST_DIV   = 4'd4;  // restoring divide per element
	localparam logic [3:0] ST_MUL   = 4'd5;  // matrix-vector product
	localparam logic [3:0] ST_MULW  = 4'd6;  // product register stage
	localparam logic [3:0] ST_EST   = 4'd7;  // accumulate product into row sum
	localparam logic [3:0] ST_ESTW  = 4'd8;
	localparam logic [3:0] ST_CHECK = 4'd9;
	localparam logic [3:0] ST_EMIT  = 4'd10;

	logic [3:0]  state_q;
	logic [3:0]  size_q;
	logic [30:0] tol_q;
	logic [15:0] cap_q;

	logic [2:0]  n_m1;
	logic [15:0] cap_eff;
	always_comb begin
		if (size_q == 4'd0)      n_m1 = 3'd0;
		else if (size_q > 4'd8)  n_m1 = 3'd7;
		else                     n_m1 = 3'(size_q - 4'd1);
		cap_eff = (cap_q == 16'd0) ? 16'd1 : cap_q;
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= 4'd8;
			tol_q  <= 31'd1;
			cap_q  <= 16'd1000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pie_pkg::REG_MATRIX_SIZE:   size_q <= cfg_data[3:0];
				pie_pkg::REG_TOLERANCE:     tol_q  <= cfg_data;
				pie_pkg::REG_ITERATION_CAP: cap_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// memories
	logic                          m_we, s_we;
	logic [pie_pkg::MADDR_BITS-1:0] m_waddr, m_raddr;
	logic [31:0]                   m_wdata, m_rdata, s_rdata;
	logic [2:0]                    s_waddr, s_raddr;

	pie_ram #(.WIDTH(32), .DEPTH(pie_pkg::MEM_DEPTH)) u_matrix (
		.clk, .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
		.raddr(m_raddr), .rdata(m_rdata));
	pie_ram #(.WIDTH(32), .DEPTH(pie_pkg::MAX_SIZE)) u_vector (
		.clk, .we(s_we), .waddr(s_waddr), .wdata(in_item.value),
		.raddr(s_raddr), .rdata(s_rdata));

	logic in_fire;
	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign m_we     = in_fire && in_item.command == pie_pkg::CMD_LOAD_MATRIX;
	assign m_waddr  = {in_item.row, in_item.col};
	assign m_wdata  = in_item.value;
	assign s_we     = in_fire && in_item.command == pie_pkg::CMD_LOAD_VECTOR;
	assign s_waddr  = in_item.row;

	// working registers (small, fixed-index vectors)
	logic signed [31:0] w_q [pie_pkg::MAX_SIZE];
	logic signed [31:0] v_q [pie_pkg::MAX_SIZE];
	logic [2:0]  i_q, k_q;
	logic [3:0]  cnt_q;          // copy and emit counter
	logic        rd_v_q;         // memory read or product valid
	logic [2:0]  rd_i_q;
	logic [65:0] sum_q;          // sum of squares, 66 bits covers 8*2^62
	logic [32:0] root_q;
	logic [5:0]  bit_q;
	logic [47:0] quo_q;
	logic [32:0] rem_q;
	logic [47:0] num_q;
	logic [5:0]  dstep_q;
	logic signed [31:0] acc_q, est_q, prev_q;
	logic signed [63:0] prod_s1;
	logic [15:0] iter_q;
	logic        conv_q;
	logic        final_q;        // normalizing after the last iteration
	logic        out_valid_q;
	pie_pkg::out_item_t out_q;

	// output register takes a new transaction when empty or being drained
	logic out_load;
	assign out_load = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	logic [31:0] mag_w;
	assign mag_w = w_q[i_q][31] ? 32'(-w_q[i_q]) : 32'(w_q[i_q]);

	// square root trial: (root | bit)^2 <= sum
	logic [32:0] cand;
	logic [65:0] cand_sq;
	assign cand    = root_q | (33'd1 << bit_q);
	assign cand_sq = 66'(cand) * 66'(cand);

	logic [33:0] rem_sh;
	assign rem_sh = {rem_q, num_q[47]};

	logic [31:0] diff;
	logic signed [32:0] dsx;
	assign dsx  = 33'(est_q) - 33'(prev_q);
	assign diff = dsx[32] ? 32'(-dsx) : 32'(dsx);

	assign m_raddr = {i_q, k_q};
	assign s_raddr = cnt_q[2:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			iter_q      <= 16'd0;
			prev_q      <= '0;
			for (int j = 0; j < pie_pkg::MAX_SIZE; j++) w_q[j] <= '0;
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire && in_item.command == pie_pkg::CMD_RUN) begin
						state_q <= ST_COPY;
						cnt_q   <= 4'd0;
						rd_v_q  <= 1'b0;
						prev_q  <= '0;
						iter_q  <= 16'd0;
						final_q <= 1'b0;
						conv_q  <= 1'b0;
					end
				end
				ST_COPY: begin
					rd_v_q <= (cnt_q < 4'd8);
					rd_i_q <= cnt_q[2:0];
					if (cnt_q < 4'd8) cnt_q <= cnt_q + 4'd1;
					if (rd_v_q) begin
						w_q[rd_i_q] <= (rd_i_q <= n_m1) ? s_rdata : '0;
						if (rd_i_q == 3'd7) begin
							state_q <= ST_SQR;
							i_q     <= 3'd0;
							sum_q   <= '0;
						end
					end
				end
				ST_SQR: begin
					sum_q <= sum_q + 66'(64'(mag_w) * 64'(mag_w));
					if (i_q == n_m1) begin
						state_q <= ST_SQRT;
						root_q  <= '0;
						bit_q   <= 6'd32;
					end else i_q <= i_q + 3'd1;
				end
				ST_SQRT: begin
					if (cand_sq <= sum_q) root_q <= cand;
					if (bit_q == 6'd0) begin
						state_q <= ST_DIV;
						i_q     <= 3'd0;
						dstep_q <= 6'd0;
					end else bit_q <= bit_q - 6'd1;
				end
				ST_DIV: begin
					if (dstep_q == 6'd0) begin
						num_q   <= {mag_w, 16'd0};
						rem_q   <= '0;
						quo_q   <= '0;
						dstep_q <= 6'd1;
					end else if (dstep_q <= 6'd48) begin
						num_q <= num_q << 1;
						if (34'(rem_sh) >= 34'(root_q)) begin
							rem_q <= 33'(rem_sh - 34'(root_q));
							quo_q <= {quo_q[46:0], 1'b1};
						end else begin
							rem_q <= rem_sh[32:0];
							quo_q <= {quo_q[46:0], 1'b0};
						end
						dstep_q <= dstep_q + 6'd1;
					end else begin
						if (root_q == 33'd0) v_q[i_q] <= '0;
						else if (w_q[i_q][31]) begin
							v_q[i_q] <= (quo_q > 48'h8000_0000) ? pie_pkg::VMIN
								: 32'(-quo_q);
						end else begin
							v_q[i_q] <= (quo_q > 48'h7FFF_FFFF) ? pie_pkg::VMAX
								: quo_q[31:0];
						end
						dstep_q <= 6'd0;
						if (i_q == n_m1) begin
							i_q <= 3'd0;
							k_q <= 3'd0;
							if (final_q) begin
								state_q <= ST_EMIT;
								cnt_q   <= 4'd0;
							end else begin
								state_q <= ST_MUL;
								acc_q   <= '0;
							end
						end else i_q <= i_q + 3'd1;
					end
				end
				ST_MUL: begin
					// address {i,k} is presented now; the read data arrives in MULW
					state_q <= ST_MULW;
				end
				ST_MULW: begin
					prod_s1 <= 64'(signed'(m_rdata)) * 64'(v_q[k_q]);
					state_q <= ST_EST;
					rd_v_q  <= 1'b1;
				end
				ST_EST: begin
					// accumulate matrix row, then move on
					if (rd_v_q) begin
						rd_v_q <= 1'b0;
						if (k_q == n_m1) begin
							w_q[i_q] <= pie_pkg::sat_add(acc_q, pie_pkg::qsat(prod_s1));
							k_q      <= 3'd0;
							acc_q    <= '0;
							if (i_q == n_m1) begin
								i_q     <= 3'd0;
								est_q   <= '0;
								state_q <= ST_ESTW;
							end else begin
								i_q     <= i_q + 3'd1;
								state_q <= ST_MUL;
							end
						end else begin
							acc_q   <= pie_pkg::sat_add(acc_q, pie_pkg::qsat(prod_s1));
							k_q     <= k_q + 3'd1;
							state_q <= ST_MUL;
						end
					end
				end
				ST_ESTW: begin
					est_q <= pie_pkg::sat_add(est_q,
						pie_pkg::qsat(64'(v_q[i_q]) * 64'(w_q[i_q])));
					if (i_q == n_m1) begin
						state_q <= ST_CHECK;
						iter_q  <= iter_q + 16'd1;
					end else i_q <= i_q + 3'd1;
				end
				ST_CHECK: begin
					prev_q  <= est_q;
					i_q     <= 3'd0;
					sum_q   <= '0;
					state_q <= ST_SQR;
					if (diff <= 32'(tol_q)) begin
						conv_q  <= 1'b1;
						final_q <= 1'b1;
					end else if (iter_q >= cap_eff) begin
						final_q <= 1'b1;
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						out_q.converged <= conv_q;
						if (cnt_q == 4'd0) begin
							out_q.kind         <= pie_pkg::KIND_VALUE;
							out_q.index        <= 3'd0;
							out_q.result_value <= est_q;
							out_q.last         <= 1'b0;
						end else begin
							out_q.kind         <= pie_pkg::KIND_VECTOR;
							out_q.index        <= 3'(cnt_q - 4'd1);
							out_q.result_value <= v_q[3'(cnt_q - 4'd1)];
							out_q.last         <= (3'(cnt_q - 4'd1) == n_m1);
						end
						if (cnt_q != 4'd0 && 3'(cnt_q - 4'd1) == n_m1) state_q <= ST_IDLE;
						cnt_q <= cnt_q + 4'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	`PIE_ASSERT(a_ready_idle, in_ready == (state_q == ST_IDLE), "ready outside idle")
	`PIE_IMPLIES(a_hold, out_valid && !out_ready, $stable(out_item) && out_valid,
		"output changed under stall")
	`PIE_ASSERT(a_iter_cap, iter_q <= cap_eff || state_q == ST_IDLE, "iteration cap passed")

endmodule

// ===== test/power_iteration_eigen_checker.sv =====
// ----------------------------------------------------------------------------
// power_iteration_eigen_checker
// Watches the load/run and result channels of the power iteration unit,
// keeps its own copy of the stores and registers, predicts every result of
// a run and compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module power_iteration_eigen_checker
	import pie_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  in_item_t    in_item,
	input  logic        out_valid,
	input  logic        out_ready,
	input  out_item_t   out_item,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [30:0] cfg_data,
	output int          errors,
	output int          pending
);

	typedef logic signed [31:0] vec_t [MAX_SIZE];

	logic signed [31:0] coeff [MAX_SIZE][MAX_SIZE];
	vec_t               start_vec;
	logic [3:0]         size_reg;
	logic [30:0]        tol_reg;
	logic [15:0]        cap_reg;
	out_item_t          eigen_results[$];

	function automatic logic signed [31:0] clamp(input logic signed [47:0] x);
		if (x > 48'(VMAX))      return VMAX;
		else if (x < 48'(VMIN)) return VMIN;
		return x[31:0];
	endfunction

	function automatic logic signed [31:0] add_clamped(input logic signed [31:0] a,
			input logic signed [31:0] b);
		return clamp(48'(a) + 48'(b));
	endfunction

	// Q16.16 product, floor rounding.
	function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [63:0] p;
		p = $signed(a) * $signed(b);
		return clamp(p >>> FRAC_BITS);
	endfunction

	// Scale to unit Euclidean length; all zero when the norm is zero.
	function automatic void unit_scale(input vec_t w, input int n, output vec_t v);
		logic [71:0] sumsq;
		logic [71:0] root;
		logic [71:0] cand;
		logic [71:0] q;
		logic [31:0] m;
		sumsq = '0;
		root  = '0;
		for (int i = 0; i < MAX_SIZE; i++) v[i] = '0;
		for (int i = 0; i < n; i++) begin
			m = w[i] < 0 ? 32'(-33'(w[i])) : w[i];
			sumsq += 72'(m) * 72'(m);
		end
		for (int b = 35; b >= 0; b--) begin
			cand = root | (72'd1 << b);
			if (cand * cand <= sumsq) root = cand;
		end
		if (root == 0) return;
		for (int i = 0; i < n; i++) begin
			m = w[i] < 0 ? 32'(-33'(w[i])) : w[i];
			q = (72'(m) << FRAC_BITS) / root;
			if (w[i] < 0) v[i] = q > 72'h8000_0000 ? VMIN : 32'(-73'(q));
			else          v[i] = q > 72'h7FFF_FFFF ? VMAX : q[31:0];
		end
	endfunction

	// Full power iteration; queues the eigenvalue and then the vector.
	task automatic predict_run();
		vec_t               w, v;
		logic signed [31:0] est, prev, acc;
		logic [32:0]        diff;
		int                 n, cap, iters;
		logic               conv;
		out_item_t          r;
		n     = size_reg == 0 ? 1 : (size_reg > MAX_SIZE ? MAX_SIZE : int'(size_reg));
		cap   = cap_reg == 0 ? 1 : int'(cap_reg);
		prev  = '0;
		iters = 0;
		conv  = 1'b0;
		for (int i = 0; i < MAX_SIZE; i++) w[i] = i < n ? start_vec[i] : '0;
		forever begin
			unit_scale(w, n, v);
			for (int i = 0; i < n; i++) begin
				acc = '0;
				for (int k = 0; k < n; k++) acc = add_clamped(acc, fx_mul(coeff[i][k], v[k]));
				w[i] = acc;
			end
			est = '0;
			for (int i = 0; i < n; i++) est = add_clamped(est, fx_mul(v[i], w[i]));
			iters++;
			diff = est >= prev ? 33'(est) - 33'(prev) : 33'(prev) - 33'(est);
			prev = est;
			if (diff <= 33'(tol_reg)) begin
				conv = 1'b1;
				break;
			end
			if (iters >= cap) break;
		end
		unit_scale(w, n, v);
		r = '{kind: KIND_VALUE, index: '0, result_value: est, converged: conv, last: 1'b0};
		eigen_results.push_back(r);
		for (int i = 0; i < n; i++) begin
			r = '{kind: KIND_VECTOR, index: 3'(i), result_value: v[i], converged: conv,
				last: (i == n - 1)};
			eigen_results.push_back(r);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t exp_r;
		if (!arst_n) begin
			size_reg = 4'd8;
			tol_reg  = 31'd1;
			cap_reg  = 16'd1000;
			errors   = 0;
			eigen_results.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MATRIX_SIZE:   size_reg = cfg_data[3:0];
					REG_TOLERANCE:     tol_reg  = cfg_data;
					REG_ITERATION_CAP: cap_reg  = cfg_data[15:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (eigen_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %p", $time, out_item);
					errors++;
				end else begin
					exp_r = eigen_results.pop_front();
					if (out_item.kind !== exp_r.kind) begin
						$display("%0t: kind expected %0d actual %0d", $time, exp_r.kind, out_item.kind);
						errors++;
					end
					if (out_item.index !== exp_r.index) begin
						$display("%0t: index expected %0d actual %0d", $time, exp_r.index,
							out_item.index);
						errors++;
					end
					if (out_item.result_value !== exp_r.result_value) begin
						$display("%0t: value expected %h actual %h", $time, exp_r.result_value,
							out_item.result_value);
						errors++;
					end
					if (out_item.converged !== exp_r.converged) begin
						$display("%0t: converged expected %0d actual %0d", $time, exp_r.converged,
							out_item.converged);
						errors++;
					end
					if (out_item.last !== exp_r.last) begin
						$display("%0t: last expected %0d actual %0d", $time, exp_r.last, out_item.last);
						errors++;
					end
				end
			end
			if (in_valid && in_ready) begin
				case (in_item.command)
					CMD_LOAD_MATRIX: coeff[in_item.row][in_item.col] = in_item.value;
					CMD_LOAD_VECTOR: start_vec[in_item.row] = in_item.value;
					CMD_RUN:         predict_run();
					default: ;
				endcase
			end
		end
		pending = eigen_results.size();
	end

endmodule

// ===== test/tb_power_iteration_eigen_unit.sv =====
// ----------------------------------------------------------------------------
// tb_power_iteration_eigen_unit
// Drives loads and runs into the power iteration unit with random gaps and
// output stalls over several register settings; a checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_power_iteration_eigen_unit;
	import pie_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;     // block ignores it
	localparam int         CYCLE_LIMIT = 10_000_000;
	localparam int         ITEM_GOAL   = 110;
	localparam logic signed [31:0] ONE = 32'sh0001_0000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_item;
	logic        out_valid;
	logic        out_ready;
	out_item_t   out_item;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [30:0] cfg_data;
	int          errors;
	int          pending;

	int          cycles;
	int          items;
	int          cur_n;        // effective matrix size in force
	logic        burst;        // both sides run without idle while set
	logic        mat_ok [MAX_SIZE][MAX_SIZE];
	logic        vec_ok [MAX_SIZE];

	power_iteration_eigen_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	power_iteration_eigen_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Watchdog: covers slow runs with stalls many times over.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Result side: a fresh stall before each transaction.
	initial begin
		int stall;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			stall = burst ? 0 : $urandom_range(0, 16);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(negedge clk);
			while (!out_valid) @(negedge clk);
		end
	end

	// Mix of full-range, unit-scale and saturating values.
	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 3))
			0:       return $urandom;
			1:       return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
			2:       return $signed($urandom_range(0, 32'h0000_8000)) - 32'sh0000_4000;
			default: return $urandom_range(0, 1) ? VMAX : VMIN;
		endcase
	endfunction

	// One transaction on the input channel, after a random gap. Called at a
	// rising edge; returns at the edge that accepted it, valid still high.
	task automatic push_item(input logic [1:0] cmd, input int r, input int c,
			input logic signed [31:0] val);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_item  <= '{command: cmd, row: 3'(r), col: 3'(c), value: val};
		in_valid <= 1'b1;
		@(negedge clk);
		while (!in_ready) @(negedge clk);
		@(posedge clk);
		if (cmd == CMD_LOAD_MATRIX) mat_ok[r][c] = 1'b1;
		if (cmd == CMD_LOAD_VECTOR) vec_ok[r] = 1'b1;
		if (cmd != CMD_UNUSED) items++;
	endtask

	// Any store entry the run will read gets written first.
	task automatic start_run();
		for (int i = 0; i < cur_n; i++) begin
			if (!vec_ok[i]) push_item(CMD_LOAD_VECTOR, i, $urandom_range(0, 7), pick_value());
			for (int k = 0; k < cur_n; k++)
				if (!mat_ok[i][k]) push_item(CMD_LOAD_MATRIX, i, k, pick_value());
		end
		push_item(CMD_RUN, $urandom_range(0, 7), $urandom_range(0, 7), $urandom);
	endtask

	// Hold off the sender until every result is back and the block is idle.
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (40) @(posedge clk);
	endtask

	// Spare upper bits of the data word carry random junk.
	task automatic set_config(input logic [3:0] size, input logic [30:0] tol,
			input logic [15:0] cap);
		cfg_we    <= 1'b1;
		cfg_index <= REG_MATRIX_SIZE;
		cfg_data  <= {27'($urandom), size};
		@(posedge clk);
		cfg_index <= REG_TOLERANCE;
		cfg_data  <= tol;
		@(posedge clk);
		cfg_index <= REG_ITERATION_CAP;
		cfg_data  <= {15'($urandom), cap};
		@(posedge clk);
		cfg_we    <= 1'b0;
		cur_n = size == 0 ? 1 : (size > MAX_SIZE ? MAX_SIZE : int'(size));
	endtask

	initial begin
		int n_loads;
		int sz;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_item   <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_MATRIX_SIZE;
		cfg_data  <= '0;
		cycles    = 0;
		items     = 0;
		burst     = 1'b0;
		for (int i = 0; i < MAX_SIZE; i++) begin
			vec_ok[i] = 1'b0;
			for (int k = 0; k < MAX_SIZE; k++) mat_ok[i][k] = 1'b0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// --- directed ---
		// 1x1 scalar 2.0: converges on the second pass with zero tolerance
		set_config(4'd1, 31'd0, 16'd4);
		push_item(CMD_LOAD_MATRIX, 0, 0, 2 * ONE);
		push_item(CMD_LOAD_VECTOR, 0, 0, ONE);
		start_run();
		// zero start vector: zero norm
		push_item(CMD_LOAD_VECTOR, 0, 5, '0);
		start_run();
		// saturating extremes, plus an ignored command and an unused corner entry
		push_item(CMD_UNUSED, 7, 7, $urandom);
		push_item(CMD_LOAD_MATRIX, 7, 7, -32'sd1);
		push_item(CMD_LOAD_MATRIX, 0, 0, VMAX);
		push_item(CMD_LOAD_VECTOR, 0, 0, VMIN);
		start_run();
		push_item(CMD_LOAD_MATRIX, 0, 0, VMIN);
		start_run();
		drain();
		// 2x2 with cap zero (one pass) and widest tolerance
		set_config(4'd2, 31'h7FFF_FFFF, 16'd0);
		push_item(CMD_LOAD_MATRIX, 0, 1, ONE);
		push_item(CMD_LOAD_MATRIX, 1, 0, ONE);
		push_item(CMD_LOAD_MATRIX, 1, 1, -3 * ONE);
		push_item(CMD_LOAD_VECTOR, 1, 0, -ONE);
		start_run();
		drain();
		// size zero acts as one; largest cap, stops at once on a small estimate
		set_config(4'd0, 31'h7FFF_FFFF, 16'hFFFF);
		push_item(CMD_LOAD_MATRIX, 0, 0, ONE / 2);
		start_run();
		drain();

		// --- random phases ---
		while (items < ITEM_GOAL) begin
			sz = $urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(0, 15);
			case ($urandom_range(0, 3))
				0:       set_config(4'(sz), 31'd0, 16'($urandom_range(1, 24)));
				1:       set_config(4'(sz), 31'($urandom_range(0, 32'h1000)),
						16'($urandom_range(0, 24)));
				2:       set_config(4'(sz), 31'($urandom), 16'($urandom_range(1, 24)));
				default: set_config(4'(sz), 31'h7FFF_FFFF, 16'($urandom_range(1, 24)));
			endcase
			burst = $urandom_range(0, 3) == 0;
			for (int s = 0; s < 3; s++) begin
				n_loads = $urandom_range(0, cur_n * cur_n + cur_n);
				for (int j = 0; j < n_loads; j++) begin
					case ($urandom_range(0, 9))
						0:       push_item(CMD_UNUSED, $urandom_range(0, 7),
								$urandom_range(0, 7), $urandom);
						1:       push_item(CMD_LOAD_MATRIX, $urandom_range(0, 7),
								$urandom_range(0, 7), pick_value());
						2, 3:    push_item(CMD_LOAD_VECTOR, $urandom_range(0, cur_n - 1),
								$urandom_range(0, 7), pick_value());
						default: push_item(CMD_LOAD_MATRIX, $urandom_range(0, cur_n - 1),
								$urandom_range(0, cur_n - 1), pick_value());
					endcase
				end
				start_run();
			end
			burst = 1'b0;
			drain();
		end

		// all results in and the block idle
		drain();
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
